// File: design/bocp_pkg.sv
package bocp_pkg;

	localparam int LENGTH_BITS = 20;
	localparam int BYTE_BITS = 8;
	localparam int ACC_BITS = 15;
	localparam int HELD_BITS = 4;
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_BITS = 2;
	localparam int RQ_CNT_BITS = 3;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SRC_BIT_OFFSET = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DST_BIT_OFFSET = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COPY_BIT_LENGTH = 2'd2;

	localparam logic [BYTE_BITS-1:0] BYTE_MASK = 8'hff;

	typedef struct packed {
		logic [BYTE_BITS-1:0] dst_byte;
		logic [BYTE_BITS-1:0] write_mask;
		logic last_out;
		logic short_source;
	} res_t;

	// Up to two result words per source word, pushed together.
	typedef struct packed {
		logic [1:0] cnt;
		res_t r0;
		res_t r1;
	} res_push_t;

endpackage

// File: design/bocp_front.sv
module bocp_front import bocp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_INDEX_BITS-1:0] cfg_index,
	input logic [LENGTH_BITS-1:0] cfg_data,
	input logic take,
	input logic [BYTE_BITS-1:0] src_byte,
	input logic src_final,
	output res_push_t rq_push,
	output logic busy
);

	logic [2:0] src_off_q;
	logic [2:0] dst_off_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [ACC_BITS-1:0] acc_q;
	logic [HELD_BITS-1:0] held_q;
	logic [LENGTH_BITS-1:0] left_q;
	logic seen_q;
	logic pending_q;

	logic active;
	logic [HELD_BITS-1:0] avail;
	logic [HELD_BITS-1:0] n;
	logic [BYTE_BITS-1:0] chunk;
	logic [ACC_BITS-1:0] acc_n;
	logic [HELD_BITS-1:0] held_n;
	logic [ACC_BITS-1:0] acc2;
	logic [HELD_BITS-1:0] held2;
	logic [LENGTH_BITS-1:0] left_n;
	logic emit_full;
	logic emit_tail;
	logic ending;
	logic short_src;
	logic [BYTE_BITS-1:0] first_mask;
	logic [BYTE_BITS-1:0] full_byte;
	logic [BYTE_BITS-1:0] tail_byte;
	logic [BYTE_BITS-1:0] tail_mask;
	logic [HELD_BITS-1:0] sh;

	assign busy = (left_q != '0);
	assign active = take && busy;

	always_comb begin
		avail = seen_q ? HELD_BITS'(BYTE_BITS) : HELD_BITS'(BYTE_BITS) - {1'b0, src_off_q};
		n = (left_q < LENGTH_BITS'(avail)) ? left_q[HELD_BITS-1:0] : avail;
		chunk = (src_byte & (BYTE_MASK >> (HELD_BITS'(BYTE_BITS) - avail))) >> (avail - n);
		acc_n = (acc_q << n) | ACC_BITS'(chunk);
		held_n = held_q + n;
		left_n = left_q - LENGTH_BITS'(n);
		short_src = src_final && (left_n != '0);
		ending = (left_n == '0) || src_final;
		emit_full = (held_n >= HELD_BITS'(BYTE_BITS));
		if (emit_full) begin
			full_byte = BYTE_BITS'(acc_n >> (held_n - HELD_BITS'(BYTE_BITS)));
			held2 = held_n - HELD_BITS'(BYTE_BITS);
			acc2 = acc_n & ~({ACC_BITS{1'b1}} << held2);
		end else begin
			full_byte = '0;
			held2 = held_n;
			acc2 = acc_n;
		end
		emit_tail = ending && (held2 != '0);
		sh = HELD_BITS'(BYTE_BITS) - held2;
		tail_byte = acc2[BYTE_BITS-1:0] << sh;
		tail_mask = BYTE_MASK << sh;
		first_mask = pending_q ? (BYTE_MASK >> dst_off_q) : BYTE_MASK;
	end

	// The first emitted word of a transfer gets the destination offset mask.
	always_comb begin
		rq_push = '0;
		if (active) begin
			if (emit_full) begin
				rq_push.r0.dst_byte = full_byte & first_mask;
				rq_push.r0.write_mask = first_mask;
				if (emit_tail) begin
					rq_push.cnt = 2'd2;
					rq_push.r1.dst_byte = tail_byte & tail_mask;
					rq_push.r1.write_mask = tail_mask;
					rq_push.r1.last_out = 1'b1;
					rq_push.r1.short_source = short_src;
				end else begin
					rq_push.cnt = 2'd1;
					rq_push.r0.last_out = ending;
					rq_push.r0.short_source = ending && short_src;
				end
			end else if (emit_tail) begin
				rq_push.cnt = 2'd1;
				rq_push.r0.dst_byte = tail_byte & tail_mask & first_mask;
				rq_push.r0.write_mask = tail_mask & first_mask;
				rq_push.r0.last_out = 1'b1;
				rq_push.r0.short_source = short_src;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_off_q <= '0;
			dst_off_q <= '0;
			len_q <= '0;
			acc_q <= '0;
			held_q <= '0;
			left_q <= '0;
			seen_q <= 1'b0;
			pending_q <= 1'b1;
		end else if (cfg_we && (cfg_index == REG_SRC_BIT_OFFSET ||
				cfg_index == REG_DST_BIT_OFFSET || cfg_index == REG_COPY_BIT_LENGTH)) begin
			// Any register write restarts the transfer with the new settings.
			acc_q <= '0;
			seen_q <= 1'b0;
			pending_q <= 1'b1;
			case (cfg_index)
				REG_SRC_BIT_OFFSET: begin
					src_off_q <= cfg_data[2:0];
					held_q <= {1'b0, dst_off_q};
					left_q <= len_q;
				end
				REG_DST_BIT_OFFSET: begin
					dst_off_q <= cfg_data[2:0];
					held_q <= {1'b0, cfg_data[2:0]};
					left_q <= len_q;
				end
				default: begin
					len_q <= cfg_data;
					held_q <= {1'b0, dst_off_q};
					left_q <= cfg_data;
				end
			endcase
		end else if (active) begin
			seen_q <= 1'b1;
			if (rq_push.cnt != 2'd0) begin
				pending_q <= 1'b0;
			end
			if (ending) begin
				acc_q <= '0;
				held_q <= '0;
				left_q <= '0;
			end else begin
				acc_q <= acc2;
				held_q <= held2;
				left_q <= left_n;
			end
		end
	end

endmodule

// File: design/bocp_rq.sv
module bocp_rq import bocp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input res_push_t rq_push,
	input logic pop,
	output res_t head,
	output logic empty,
	output logic full,
	output logic [RQ_CNT_BITS-1:0] level
);

	res_t mem_q [RQ_DEPTH];
	logic [RQ_PTR_BITS-1:0] wr_q;
	logic [RQ_PTR_BITS-1:0] rd_q;
	logic [RQ_CNT_BITS-1:0] cnt_q;
	logic do_pop;

	assign empty = (cnt_q == '0);
	// Room for the two words that one source word may produce.
	assign full = (cnt_q > RQ_CNT_BITS'(RQ_DEPTH - 2));
	assign level = cnt_q;
	assign head = mem_q[rd_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (rq_push.cnt != 2'd0) begin
			mem_q[wr_q] <= rq_push.r0;
		end
		if (rq_push.cnt == 2'd2) begin
			mem_q[wr_q + RQ_PTR_BITS'(1)] <= rq_push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + RQ_PTR_BITS'(rq_push.cnt);
			if (do_pop) begin
				rd_q <= rd_q + RQ_PTR_BITS'(1);
			end
			cnt_q <= cnt_q + RQ_CNT_BITS'(rq_push.cnt) - RQ_CNT_BITS'(do_pop);
		end
	end

endmodule

// File: design/bit_offset_copy_aligner.sv
// Bit offset copy aligner: copies copy_bit_length bits, most significant bit
// first, from bit src_bit_offset of the first source word to bit
// dst_bit_offset of the first destination word.
// Source words enter through push/full; an input word is taken on an edge
// with push high and full low. Destination words leave through empty/pop,
// each with a write mask for a masked write, last_out on the final word and
// short_source when src_final came before all bits were copied.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while idle, which the block itself does not enforce. Any register
// write starts a new transfer. Index 3 is ignored. The front register stage
// updates the bit accumulator per source word and pushes zero, one or two
// result words into a four-entry result queue; a result is registered in the
// queue and shows on the output ports once the words before it are popped.
// One source word per cycle is accepted while the queue holds two words or
// fewer, so the output side sets the sustained rate: one result word per cycle while pop is high.
// When pop stays low the queue fills and full rises; no word is lost.
// Reset zeroes the offsets, the length and the bit accumulator: zero length, so
// input words are dropped without a result until copy_bit_length is written.
module bit_offset_copy_aligner import bocp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_INDEX_BITS-1:0] cfg_index,
	input logic [LENGTH_BITS-1:0] cfg_data,
	input logic push,
	output logic full,
	input logic [BYTE_BITS-1:0] src_byte,
	input logic src_final,
	output logic empty,
	input logic pop,
	output logic [BYTE_BITS-1:0] dst_byte,
	output logic [BYTE_BITS-1:0] write_mask,
	output logic last_out,
	output logic short_source
);

	res_push_t rq_push;
	res_t head;
	logic busy;
	logic [RQ_CNT_BITS-1:0] level;

	bocp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.take(push && !full),
		.src_byte(src_byte),
		.src_final(src_final),
		.rq_push(rq_push),
		.busy(busy)
	);

	bocp_rq u_rq (
		.clk(clk),
		.arst_n(arst_n),
		.rq_push(rq_push),
		.pop(pop),
		.head(head),
		.empty(empty),
		.full(full),
		.level(level)
	);

	assign dst_byte = head.dst_byte;
	assign write_mask = head.write_mask;
	assign last_out = head.last_out;
	assign short_source = head.short_source;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= RQ_CNT_BITS'(RQ_DEPTH))
		else $error("result queue overflow");

	a_idle_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> rq_push.cnt == 2'd0)
		else $error("result produced with no transfer active");

	a_mask_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> write_mask != '0)
		else $error("result word with empty write mask");

	a_data_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (dst_byte & ~write_mask) == '0)
		else $error("data bits outside write mask");

	a_short_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && short_source |-> last_out)
		else $error("short source flag on a word that is not last");

endmodule

// File: tb/bocp_checker.sv
`timescale 1ns / 1ps

module bocp_checker import bocp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_INDEX_BITS-1:0] cfg_index,
	input logic [LENGTH_BITS-1:0] cfg_data,
	input logic push,
	input logic full,
	input logic [BYTE_BITS-1:0] src_byte,
	input logic src_final,
	input logic empty,
	input logic pop,
	input logic [BYTE_BITS-1:0] dst_byte,
	input logic [BYTE_BITS-1:0] write_mask,
	input logic last_out,
	input logic short_source,
	output int errors,
	output int pending_words
);

	logic [2:0] src_off;
	logic [2:0] dst_off;
	logic [LENGTH_BITS-1:0] copy_len;

	logic [ACC_BITS-1:0] acc;
	logic [HELD_BITS-1:0] held;
	logic [LENGTH_BITS-1:0] left;
	logic lead_seen;
	logic lead_dst_open;

	res_t dst_words_due[$];
	int n_err = 0;

	task automatic report(input string msg);
		n_err++;
		if (n_err <= 100) begin
			$display("MISMATCH at %0t ns: %s", $time, msg);
		end
	endtask

	task automatic restart_copy();
		acc = '0;
		held = {1'b0, dst_off};
		left = copy_len;
		lead_seen = 1'b0;
		lead_dst_open = 1'b1;
	endtask

	// The first destination word only covers the bits from the destination offset on.
	function automatic logic [BYTE_BITS-1:0] lead_mask();
		logic [BYTE_BITS-1:0] m;
		m = BYTE_MASK;
		if (lead_dst_open) begin
			m = BYTE_MASK >> dst_off;
			lead_dst_open = 1'b0;
		end
		return m;
	endfunction

	task automatic align_word(input logic [BYTE_BITS-1:0] b, input logic fin);
		int avail;
		int n;
		int chunk;
		int sh;
		logic [BYTE_BITS-1:0] val;
		logic [BYTE_BITS-1:0] mask;
		logic ending;
		logic short_src;
		res_t w[2];
		int cnt;
		cnt = 0;
		if (left == 0) begin
			return;
		end
		avail = lead_seen ? BYTE_BITS : BYTE_BITS - src_off;
		n = (avail > left) ? int'(left) : avail;
		// Take the next n bits of the word, dropping any beyond the copy length.
		chunk = (int'(b) & ((1 << avail) - 1)) >> (avail - n);
		acc = ACC_BITS'((int'(acc) << n) | chunk);
		held = held + HELD_BITS'(n);
		left = left - LENGTH_BITS'(n);
		lead_seen = 1'b1;
		short_src = fin && (left != 0);
		ending = (left == 0) || fin;
		if (held >= BYTE_BITS) begin
			val = BYTE_BITS'(int'(acc) >> (held - BYTE_BITS));
			held = held - HELD_BITS'(BYTE_BITS);
			acc = ACC_BITS'(int'(acc) & ((1 << held) - 1));
			mask = lead_mask();
			w[cnt] = '{dst_byte: val & mask, write_mask: mask, last_out: 1'b0,
				short_source: 1'b0};
			cnt++;
		end
		if (ending && held > 0) begin
			sh = BYTE_BITS - held;
			val = BYTE_BITS'(int'(acc) << sh);
			mask = BYTE_MASK << sh;
			mask = mask & lead_mask();
			w[cnt] = '{dst_byte: val & mask, write_mask: mask, last_out: 1'b0,
				short_source: 1'b0};
			cnt++;
		end
		if (ending) begin
			if (cnt > 0) begin
				w[cnt-1].last_out = 1'b1;
				w[cnt-1].short_source = short_src;
			end
			left = '0;
			held = '0;
			acc = '0;
		end
		for (int i = 0; i < cnt; i++) begin
			dst_words_due.push_back(w[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			src_off = '0;
			dst_off = '0;
			copy_len = '0;
			restart_copy();
			dst_words_due.delete();
			pending_words <= 0;
		end else begin
			if (pop && empty === 1'b0) begin
				got = '{dst_byte: dst_byte, write_mask: write_mask, last_out: last_out,
					short_source: short_source};
				if (dst_words_due.size() == 0) begin
					report($sformatf("word %02h mask %02h arrived with nothing expected",
						dst_byte, write_mask));
				end else begin
					want = dst_words_due.pop_front();
					if (got.dst_byte !== want.dst_byte)
						report($sformatf("dst_byte got %02h, expected %02h",
							got.dst_byte, want.dst_byte));
					if (got.write_mask !== want.write_mask)
						report($sformatf("write_mask got %02h, expected %02h",
							got.write_mask, want.write_mask));
					if (got.last_out !== want.last_out)
						report($sformatf("last_out got %b, expected %b",
							got.last_out, want.last_out));
					if (got.short_source !== want.short_source)
						report($sformatf("short_source got %b, expected %b",
							got.short_source, want.short_source));
				end
			end
			if (cfg_we === 1'b1) begin
				case (cfg_index)
					REG_SRC_BIT_OFFSET: begin
						src_off = cfg_data[2:0];
						restart_copy();
					end
					REG_DST_BIT_OFFSET: begin
						dst_off = cfg_data[2:0];
						restart_copy();
					end
					REG_COPY_BIT_LENGTH: begin
						copy_len = cfg_data;
						restart_copy();
					end
					default: begin
					end
				endcase
			end
			if (push && full === 1'b0) begin
				align_word(src_byte, src_final);
			end
			pending_words <= dst_words_due.size();
		end
		errors <= n_err;
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bocp_pkg::*;

	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 1000;
	localparam int RANDOM_WORDS = 650;
	localparam int CALM_AFTER = 560;
	localparam int PRESSURE_AT = 200;
	localparam int PRESSURE_BITS = 480;
	localparam int LONG_HOLD = 80;

	typedef enum {END_EXACT, END_SHORT, END_EXTRA} src_end_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [LENGTH_BITS-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic [BYTE_BITS-1:0] src_byte = '0;
	logic src_final = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	logic [BYTE_BITS-1:0] dst_byte;
	logic [BYTE_BITS-1:0] write_mask;
	logic last_out;
	logic short_source;

	logic hold_req = 1'b0;
	logic calm = 1'b0;
	bit sender_gaps = 1'b1;
	int fed_words = 0;
	int errors;
	int pending_words;

	bit_offset_copy_aligner dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.src_byte(src_byte),
		.src_final(src_final),
		.empty(empty),
		.pop(pop),
		.dst_byte(dst_byte),
		.write_mask(write_mask),
		.last_out(last_out),
		.short_source(short_source)
	);

	bocp_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.src_byte(src_byte),
		.src_final(src_final),
		.empty(empty),
		.pop(pop),
		.dst_byte(dst_byte),
		.write_mask(write_mask),
		.last_out(last_out),
		.short_source(short_source),
		.errors(errors),
		.pending_words(pending_words)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Result side: short random stalls, quiet windows, and one long hold-off on request.
	initial begin
		int hold;
		int window;
		bit stalls;
		hold = 0;
		window = 0;
		stalls = 1'b1;
		forever begin
			@(posedge clk);
			if (window == 0) begin
				window = 64;
				stalls = $urandom_range(0, 2) != 0;
			end
			window--;
			if (hold_req) begin
				hold = LONG_HOLD;
				pop <= 1'b0;
			end else if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else if (!calm && stalls && $urandom_range(0, 6) == 0) begin
				hold = $urandom_range(1, 9) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((push && full === 1'b0) || (pop && empty === 1'b0) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [LENGTH_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Wait until every expected word is out and the block has had time to go quiet.
	task automatic settle();
		do @(posedge clk); while (pending_words != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_transfer(input int s, input int d, input int len);
		logic [LENGTH_BITS-1:0] v;
		settle();
		v = LENGTH_BITS'($urandom);
		v[2:0] = s[2:0];
		write_reg(REG_SRC_BIT_OFFSET, v);
		v = LENGTH_BITS'($urandom);
		v[2:0] = d[2:0];
		write_reg(REG_DST_BIT_OFFSET, v);
		write_reg(REG_COPY_BIT_LENGTH, LENGTH_BITS'(len));
		cfg_we <= 1'b0;
	endtask

	task automatic send_word(input logic [BYTE_BITS-1:0] b, input logic fin);
		if (sender_gaps && !calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		push <= 1'b1;
		src_byte <= b;
		src_final <= fin;
		@(posedge clk);
		while (full !== 1'b0) @(posedge clk);
	endtask

	task automatic run_stream(input int s, input int len, input src_end_t how);
		int need;
		int n_send;
		int last_at;
		need = (len == 0) ? 0 : (s + len + 7) / 8;
		last_at = -1;
		case (how)
			END_EXACT: begin
				n_send = need;
				if ($urandom_range(0, 1)) last_at = need - 1;
			end
			END_SHORT: begin
				n_send = (need > 1) ? $urandom_range(1, need - 1) : 1;
				last_at = n_send - 1;
			end
			default: begin
				// Words past the end of the transfer are dropped by the block.
				n_send = need + $urandom_range(1, 3);
				if ($urandom_range(0, 1)) last_at = n_send - 1;
			end
		endcase
		if (len == 0) n_send = $urandom_range(1, 2);
		for (int i = 0; i < n_send; i++) begin
			send_word(BYTE_BITS'($urandom_range(0, 255)), i == last_at);
		end
		push <= 1'b0;
		fed_words += (n_send < need) ? n_send : need;
	endtask

	initial begin
		int s;
		int d;
		int len;
		int k;
		bit pressed;
		src_end_t how;
		pressed = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero length after reset: words are dropped without a result.
		send_word(8'hff, 1'b1);
		send_word(8'h00, 1'b0);
		push <= 1'b0;

		set_transfer(0, 0, 8);
		send_word(8'hff, 1'b1);
		push <= 1'b0;

		set_transfer(7, 7, 1);
		send_word(8'h01, 1'b0);
		push <= 1'b0;

		set_transfer(3, 5, 13);
		send_word(8'ha5, 1'b0);
		send_word(8'h5a, 1'b1);
		push <= 1'b0;

		// A write to the unused index must not restart the transfer in progress.
		set_transfer(0, 7, 20);
		send_word(8'hc3, 1'b0);
		push <= 1'b0;
		settle();
		write_reg(REG_UNUSED, '1);
		cfg_we <= 1'b0;
		send_word(8'h3c, 1'b0);
		send_word(8'h00, 1'b0);
		push <= 1'b0;

		// Source ends early with both offsets nonzero.
		set_transfer(5, 2, 40);
		send_word(8'hff, 1'b0);
		send_word(8'h81, 1'b1);
		push <= 1'b0;

		set_transfer(2, 0, (1 << LENGTH_BITS) - 1);
		send_word(8'h00, 1'b0);
		send_word(8'hff, 1'b0);
		send_word(8'h7e, 1'b1);
		push <= 1'b0;

		set_transfer(1, 3, 0);
		send_word(8'haa, 1'b1);
		push <= 1'b0;

		set_transfer(6, 1, 10);
		run_stream(6, 10, END_EXTRA);

		// Length alone rewritten; both offsets stay as they were.
		settle();
		write_reg(REG_COPY_BIT_LENGTH, LENGTH_BITS'(9));
		cfg_we <= 1'b0;
		run_stream(6, 9, END_EXACT);

		fed_words = 0;
		s = 6;
		while (fed_words < RANDOM_WORDS) begin
			if (fed_words >= CALM_AFTER) calm <= 1'b1;
			sender_gaps = $urandom_range(0, 3) != 0;
			if (!pressed && fed_words >= PRESSURE_AT) begin
				// Hold the result side off while the source streams at full rate.
				pressed = 1'b1;
				s = $urandom_range(0, 7);
				d = $urandom_range(0, 7);
				set_transfer(s, d, PRESSURE_BITS);
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
				sender_gaps = 1'b0;
				run_stream(s, PRESSURE_BITS, END_EXACT);
				continue;
			end
			k = $urandom_range(0, 19);
			len = (k == 0) ? 0 : (k < 15) ? $urandom_range(1, 40) : $urandom_range(41, 200);
			if ($urandom_range(0, 4) == 0) begin
				settle();
				write_reg(REG_COPY_BIT_LENGTH, LENGTH_BITS'(len));
				cfg_we <= 1'b0;
			end else begin
				s = $urandom_range(0, 7);
				d = $urandom_range(0, 7);
				set_transfer(s, d, len);
			end
			k = $urandom_range(0, 9);
			how = (k < 7) ? END_EXACT : (k < 9) ? END_SHORT : END_EXTRA;
			run_stream(s, len, how);
		end

		settle();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: bit_offset_copy_aligner.f
design/bocp_pkg.sv
design/bocp_front.sv
design/bocp_rq.sv
design/bit_offset_copy_aligner.sv
tb/bocp_checker.sv
tb/tb_top.sv
